// ===== sv/vcu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vcu_pkg;

   localparam int DIV_NW = 52;
   localparam int DIV_DW = 36;
   localparam int SQ_RW = 66;
   localparam int SQ_QW = 33;

   localparam logic signed [31:0] MAX_COORD = 32'sd1966080000;
   localparam logic [31:0] ERR_INIT = 32'd655360;
   localparam logic [31:0] ERR_MIN = 32'd6554;
   localparam logic [31:0] ERR_CONV = 32'd3276800;
   localparam logic [39:0] RTT_CONV = 40'd655360;
   localparam logic [39:0] RTT_MAX = 40'd19660800000;
   localparam logic [2:0] CONV_LIMIT = 3'd5;
   localparam logic [16:0] RECIP10 = 17'd52429;

   localparam logic [2:0] ST_UPDATED = 3'd0;
   localparam logic [2:0] ST_BAD_COORD = 3'd1;
   localparam logic [2:0] ST_BAD_RTT = 3'd2;
   localparam logic [2:0] ST_ZERO_SUM = 3'd3;
   localparam logic [2:0] ST_ORIGIN = 3'd4;

   typedef struct packed {
      logic start;
      logic [DIV_NW-1:0] num;
      logic [DIV_DW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic start;
      logic [SQ_RW-1:0] rad;
   } sqrt_req_type;

   typedef enum logic [25:0] {
      S_IDLE  = 26'b1 << 0,
      S_CHECK = 26'b1 << 1,
      S_WDIV  = 26'b1 << 2,
      S_SQA   = 26'b1 << 3,
      S_SQB   = 26'b1 << 4,
      S_SQC   = 26'b1 << 5,
      S_SQW   = 26'b1 << 6,
      S_ESW   = 26'b1 << 7,
      S_T1A   = 26'b1 << 8,
      S_T1B   = 26'b1 << 9,
      S_T2    = 26'b1 << 10,
      S_T3    = 26'b1 << 11,
      S_SC    = 26'b1 << 12,
      S_VA    = 26'b1 << 13,
      S_VB    = 26'b1 << 14,
      S_VC    = 26'b1 << 15,
      S_VW    = 26'b1 << 16,
      S_UXW   = 26'b1 << 17,
      S_UYW   = 26'b1 << 18,
      S_UHW   = 26'b1 << 19,
      S_MX    = 26'b1 << 20,
      S_MY    = 26'b1 << 21,
      S_MH    = 26'b1 << 22,
      S_MF    = 26'b1 << 23,
      S_PEND  = 26'b1 << 24,
      S_DONE  = 26'b1 << 25
   } state_type;

   function automatic logic in_range32(input logic signed [31:0] v);
      return (v >= -MAX_COORD) && (v <= MAX_COORD);
   endfunction

   function automatic logic in_range38(input logic signed [37:0] v);
      return (v >= -38'(MAX_COORD)) && (v <= 38'(MAX_COORD));
   endfunction

   function automatic logic [12:0] div10(input logic [15:0] v);
      logic [32:0] p;
      p = {17'b0, v} * {16'b0, RECIP10};
      return p[31:19];
   endfunction

endpackage
`default_nettype wire

// ===== sv/vivaldi_coordinate_update_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Width  Contents
// req      in   248    one sample with remote coordinate, error and random fractions
// rsp      out  136    own coordinate, error and status after the sample
//
// Each update pass runs five divisions on the shared restoring divider and two square
// roots; a sample that triggers the convergence pass runs the update pass a second time,
// and a zero direction adds one root. Rejected samples skip the arithmetic.
// Reset is synchronous and clears the coordinate to the origin with error 10.0. A new
// item is taken while a result still waits in the output register; a stalled result
// holds the sequencer at its end.
module vivaldi_coordinate_update_core
   import vcu_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // rtt_sample, remote_x, remote_y, remote_h, remote_error, jitter_x, jitter_y,
   // fallback_x, fallback_y, fallback_h
   input  wire logic [247:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // own_x, own_y, own_h, own_error, status, zero fill
   output logic [135:0]      rsp_tdata
);

   state_type state_ff, state_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in, ch_ff, ch_in;
   logic [31:0] err_ff, err_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [39:0] prtt_ff, prtt_in;
   logic signed [31:0] prx_ff, prx_in, pry_ff, pry_in, prh_ff, prh_in;
   logic [31:0] pej_ff, pej_in;
   logic [15:0] jx_ff, jx_in, jy_ff, jy_in, fx_ff, fx_in, fy_ff, fy_in, fh_ff, fh_in;
   logic nz_ff, nz_in, pass2_ff, pass2_in, fb_ff, fb_in;
   logic [2:0] st_ff, st_in;
   logic signed [34:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [32:0] hs_ff, hs_in;
   logic [16:0] w_ff, w_in, ux_ff, ux_in, uy_ff, uy_in, uh_ff, uh_in;
   logic [63:0] sa_ff, sa_in;
   logic signed [40:0] re_ff, re_in;
   logic [51:0] es_ff, es_in, t1_ff, t1_in;
   logic [31:0] ne_ff, ne_in;
   logic [34:0] scm_ff, scm_in;
   logic scn_ff, scn_in;
   logic [33:0] m_ff, m_in;
   logic signed [37:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [67:0] p_ff, p_in;
   logic [130:0] out_ff, out_in;
   logic ovalid_ff, ovalid_in;

   logic [35:0] mul_a;
   logic [31:0] mul_b;
   div_req_type div_req;
   sqrt_req_type sq_req;
   logic div_done, sq_done;
   logic [DIV_NW-1:0] div_quo;
   logic [SQ_QW-1:0] sq_root;

   logic bad_coord;
   logic [32:0] sum33;
   logic signed [33:0] hsum;
   logic [31:0] absrh;
   logic [33:0] range_sum;
   logic [40:0] re_abs;
   logic [34:0] axabs, ayabs;
   logic [33:0] msum;
   logic [51:0] ne_sum;
   logic [36:0] mv;
   logic signed [37:0] sv, nsum, nh;
   logic fits;

   always_comb begin
      state_in = state_ff;
      cx_in = cx_ff; cy_in = cy_ff; ch_in = ch_ff; err_in = err_ff; cnt_in = cnt_ff;
      prtt_in = prtt_ff; prx_in = prx_ff; pry_in = pry_ff; prh_in = prh_ff;
      pej_in = pej_ff;
      jx_in = jx_ff; jy_in = jy_ff; fx_in = fx_ff; fy_in = fy_ff; fh_in = fh_ff;
      nz_in = nz_ff; pass2_in = pass2_ff; fb_in = fb_ff; st_in = st_ff;
      ax_in = ax_ff; ay_in = ay_ff; hs_in = hs_ff; w_in = w_ff; sa_in = sa_ff;
      re_in = re_ff; es_in = es_ff; t1_in = t1_ff; ne_in = ne_ff;
      scm_in = scm_ff; scn_in = scn_ff; m_in = m_ff;
      ux_in = ux_ff; uy_in = uy_ff; uh_in = uh_ff; nx_in = nx_ff; ny_in = ny_ff;
      out_in = out_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      mul_a = '0;
      mul_b = '0;
      div_req = '0;
      sq_req = '0;

      bad_coord = !in_range32(cx_ff) || !in_range32(cy_ff) || !in_range32(ch_ff) ||
                  !in_range32(prx_ff) || !in_range32(pry_ff) || !in_range32(prh_ff);
      sum33 = {1'b0, err_ff} + {1'b0, pej_ff};
      absrh = prh_ff[31] ? 32'(-prh_ff) : prh_ff;
      range_sum = {1'b0, sq_root} + {1'b0, hs_ff};
      re_abs = re_ff[40] ? 41'(-re_ff) : re_ff;
      axabs = ax_ff[34] ? 35'(-ax_ff) : ax_ff;
      ayabs = ay_ff[34] ? 35'(-ay_ff) : ay_ff;
      msum = {1'b0, sq_root} + {1'b0, hs_ff};
      ne_sum = t1_ff + {1'b0, p_ff[67:17]};
      mv = p_ff[52:16];
      sv = (state_ff == S_MY) ? ((ax_ff[34] ^ scn_ff) ? -$signed({1'b0, mv}) :
                                 $signed({1'b0, mv}))
                              : (scn_ff ? -$signed({1'b0, mv}) : $signed({1'b0, mv}));
      nsum = $signed({{6{ch_ff[31]}}, ch_ff}) + sv;
      nh = nsum[37] ? -nsum : nsum;
      fits = in_range38(nx_ff) && in_range38(ny_ff) && in_range38(nh);
      hsum = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               prtt_in = req_tdata[39:0];
               prx_in = req_tdata[71:40];
               pry_in = req_tdata[103:72];
               prh_in = req_tdata[135:104];
               pej_in = req_tdata[167:136];
               jx_in = req_tdata[183:168];
               jy_in = req_tdata[199:184];
               fx_in = req_tdata[215:200];
               fy_in = req_tdata[231:216];
               fh_in = req_tdata[247:232];
               nz_in = (req_tdata[71:40] != 32'd0) || (req_tdata[103:72] != 32'd0);
               pass2_in = 1'b0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            fb_in = 1'b0;
            if (bad_coord) begin
               st_in = ST_BAD_COORD;
               state_in = S_DONE;
            end else if (prtt_ff == 40'd0 || prtt_ff > RTT_MAX) begin
               st_in = ST_BAD_RTT;
               state_in = S_DONE;
            end else if (sum33 == 33'd0) begin
               st_in = ST_ZERO_SUM;
               state_in = S_DONE;
            end else begin
               ax_in = {{3{cx_ff[31]}}, cx_ff} - {{3{prx_ff[31]}}, prx_ff};
               ay_in = {{3{cy_ff[31]}}, cy_ff} - {{3{pry_ff[31]}}, pry_ff};
               hsum = {{2{ch_ff[31]}}, ch_ff} + {{2{prh_ff[31]}}, prh_ff};
               hs_in = hsum[33] ? 33'(-hsum) : hsum[32:0];
               div_req.start = 1'b1;
               div_req.num = {4'b0, err_ff, 16'b0};
               div_req.den = {3'b0, sum33};
               state_in = S_WDIV;
            end
         end
         S_WDIV: begin
            if (div_done) begin
               w_in = div_quo[16:0];
               state_in = S_SQA;
            end
         end
         S_SQA, S_VA: begin
            mul_a = {1'b0, axabs};
            mul_b = axabs[31:0];
            state_in = (state_ff == S_SQA) ? S_SQB : S_VB;
         end
         S_SQB, S_VB: begin
            sa_in = p_ff[63:0];
            mul_a = {1'b0, ayabs};
            mul_b = ayabs[31:0];
            state_in = (state_ff == S_SQB) ? S_SQC : S_VC;
         end
         S_SQC, S_VC: begin
            sq_req.start = 1'b1;
            sq_req.rad = {2'b0, sa_ff} + {2'b0, p_ff[63:0]};
            state_in = (state_ff == S_SQC) ? S_SQW : S_VW;
         end
         S_SQW: begin
            if (sq_done) begin
               re_in = $signed({1'b0, prtt_ff}) - $signed({7'b0, range_sum});
               div_req.start = 1'b1;
               re_abs = (41'($signed({1'b0, prtt_ff}) - $signed({7'b0, range_sum})));
               re_abs = re_abs[40] ? 41'(-re_abs) : re_abs;
               div_req.num = {re_abs[35:0], 16'b0};
               div_req.den = prtt_ff[35:0];
               state_in = S_ESW;
            end
         end
         S_ESW: begin
            if (div_done) begin
               es_in = div_quo;
               state_in = S_T1A;
            end
         end
         S_T1A: begin
            mul_a = {1'b0, es_ff[51:17]};
            mul_b = {15'b0, w_ff};
            state_in = S_T1B;
         end
         S_T1B: begin
            t1_in = p_ff[51:0];
            mul_a = {19'b0, es_ff[16:0]};
            mul_b = {15'b0, w_ff};
            state_in = S_T2;
         end
         S_T2: begin
            t1_in = t1_ff + {1'b0, p_ff[67:17]};
            mul_a = {4'b0, err_ff};
            mul_b = {14'b0, 18'd131072 - {1'b0, w_ff}};
            state_in = S_T3;
         end
         S_T3: begin
            ne_in = (ne_sum[51:32] != 20'd0) ? 32'hFFFFFFFF : ne_sum[31:0];
            mul_a = re_abs[35:0];
            mul_b = {15'b0, w_ff};
            state_in = S_SC;
         end
         S_SC: begin
            scm_in = p_ff[52:18];
            scn_in = re_ff[40];
            ax_in = {{3{cx_ff[31]}}, cx_ff} -
                    ({{3{prx_ff[31]}}, prx_ff} + {22'b0, div10(jx_ff)});
            ay_in = {{3{cy_ff[31]}}, cy_ff} -
                    ({{3{pry_ff[31]}}, pry_ff} + {22'b0, div10(jy_ff)});
            hsum = {{2{ch_ff[31]}}, ch_ff} + {2'b0, absrh};
            hs_in = hsum[33] ? 33'(-hsum) : hsum[32:0];
            state_in = S_VA;
         end
         S_VW: begin
            if (sq_done) begin
               if (msum == 34'd0) begin
                  if (!fb_ff) begin
                     fb_in = 1'b1;
                     ax_in = {19'b0, fx_ff};
                     ay_in = {19'b0, fy_ff};
                     hs_in = {17'b0, fh_ff};
                     state_in = S_VA;
                  end else begin
                     cx_in = '0; cy_in = '0; ch_in = '0; err_in = ERR_INIT;
                     st_in = ST_ORIGIN;
                     state_in = S_PEND;
                  end
               end else begin
                  m_in = msum;
                  div_req.start = 1'b1;
                  div_req.num = {4'b0, axabs[31:0], 16'b0};
                  div_req.den = {2'b0, msum};
                  state_in = S_UXW;
               end
            end
         end
         S_UXW: begin
            if (div_done) begin
               ux_in = div_quo[16:0];
               div_req.start = 1'b1;
               div_req.num = {4'b0, ayabs[31:0], 16'b0};
               div_req.den = {2'b0, m_ff};
               state_in = S_UYW;
            end
         end
         S_UYW: begin
            if (div_done) begin
               uy_in = div_quo[16:0];
               div_req.start = 1'b1;
               div_req.num = {3'b0, hs_ff, 16'b0};
               div_req.den = {2'b0, m_ff};
               state_in = S_UHW;
            end
         end
         S_UHW: begin
            if (div_done) begin
               uh_in = div_quo[16:0];
               state_in = S_MX;
            end
         end
         S_MX: begin
            mul_a = {1'b0, scm_ff};
            mul_b = {15'b0, ux_ff};
            state_in = S_MY;
         end
         S_MY: begin
            nx_in = $signed({{6{cx_ff[31]}}, cx_ff}) + sv;
            mul_a = {1'b0, scm_ff};
            mul_b = {15'b0, uy_ff};
            state_in = S_MH;
         end
         S_MH: begin
            ny_in = $signed({{6{cy_ff[31]}}, cy_ff}) +
                    ((ay_ff[34] ^ scn_ff) ? -$signed({1'b0, mv}) : $signed({1'b0, mv}));
            mul_a = {1'b0, scm_ff};
            mul_b = {15'b0, uh_ff};
            state_in = S_MF;
         end
         S_MF: begin
            if (fits) begin
               cx_in = nx_ff[31:0];
               cy_in = ny_ff[31:0];
               ch_in = nh[31:0];
               err_in = (ne_ff > ERR_MIN) ? ne_ff : ERR_MIN;
               if (!pass2_ff) begin
                  st_in = ST_UPDATED;
               end
            end else begin
               cx_in = '0; cy_in = '0; ch_in = '0; err_in = ERR_INIT;
               st_in = ST_ORIGIN;
            end
            state_in = S_PEND;
         end
         S_PEND: begin
            if (pass2_ff) begin
               state_in = S_DONE;
            end else if ((cnt_ff + {2'b0, nz_ff}) > CONV_LIMIT) begin
               cnt_in = '0;
               pass2_in = 1'b1;
               prtt_in = RTT_CONV;
               prx_in = '0; pry_in = '0; prh_in = '0;
               pej_in = ERR_CONV;
               state_in = S_CHECK;
            end else begin
               cnt_in = cnt_ff + {2'b0, nz_ff};
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!ovalid_ff || rsp_tready) begin
               out_in = {st_ff, err_ff, ch_ff, cy_ff, cx_ff};
               ovalid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      p_in = {32'b0, mul_a} * {36'b0, mul_b};
   end

   vcu_div u_div (
      .clock(clock), .reset(reset), .req(div_req), .done(div_done), .quo(div_quo)
   );

   vcu_sqrt u_sqrt (
      .clock(clock), .reset(reset), .req(sq_req), .done(sq_done), .root(sq_root)
   );

   always_ff @(posedge clock) begin
      prtt_ff <= prtt_in; prx_ff <= prx_in; pry_ff <= pry_in; prh_ff <= prh_in;
      pej_ff <= pej_in;
      jx_ff <= jx_in; jy_ff <= jy_in; fx_ff <= fx_in; fy_ff <= fy_in; fh_ff <= fh_in;
      nz_ff <= nz_in; pass2_ff <= pass2_in; fb_ff <= fb_in; st_ff <= st_in;
      ax_ff <= ax_in; ay_ff <= ay_in; hs_ff <= hs_in; w_ff <= w_in; sa_ff <= sa_in;
      re_ff <= re_in; es_ff <= es_in; t1_ff <= t1_in; ne_ff <= ne_in;
      scm_ff <= scm_in; scn_ff <= scn_in; m_ff <= m_in;
      ux_ff <= ux_in; uy_ff <= uy_in; uh_ff <= uh_in; nx_ff <= nx_in; ny_ff <= ny_in;
      p_ff <= p_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff <= S_IDLE;
         cx_ff <= '0;
         cy_ff <= '0;
         ch_ff <= '0;
         err_ff <= ERR_INIT;
         cnt_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         ch_ff <= ch_in;
         err_ff <= err_in;
         cnt_ff <= cnt_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = {5'b0, out_ff};

   a_div_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_WDIV || state_ff == S_ESW || state_ff == S_UXW ||
                    state_ff == S_UYW || state_ff == S_UHW))
      else $error("divider finished outside a wait state");

   a_sqrt_expected: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> (state_ff == S_SQW || state_ff == S_VW))
      else $error("square root finished outside a wait state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CONV_LIMIT)
      else $error("update count passed the convergence point");

   a_coord_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (in_range32(cx_ff) && in_range32(cy_ff) &&
                                in_range32(ch_ff) && !ch_ff[31]))
      else $error("stored coordinate out of range");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[130:128] <= ST_ORIGIN))
      else $error("result carries an undefined status");

endmodule
`default_nettype wire

// ===== sv/vcu_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vcu_div
   import vcu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire div_req_type       req,
   output logic                   done,
   output logic [DIV_NW-1:0]      quo
);

   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DIV_DW:0] shifted;
   logic [DIV_DW:0] diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_NW-1]};
      diff = shifted - {1'b0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in = '0;
         quo_in = req.num;
         den_in = req.den;
         cnt_in = 6'(DIV_NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_DW-1:0];
            quo_in = {quo_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo = quo_ff;

endmodule
`default_nettype wire

// ===== sv/vcu_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vcu_sqrt
   import vcu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sqrt_req_type      req,
   output logic                   done,
   output logic [SQ_QW-1:0]       root
);

   logic [SQ_RW-1:0] rad_ff, rad_in;
   logic [SQ_QW+1:0] rem_ff, rem_in;
   logic [SQ_QW-1:0] root_ff, root_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [SQ_QW+3:0] rem2;
   logic [SQ_QW+3:0] trial;
   logic [SQ_QW+3:0] diff;

   always_comb begin
      rem2 = {rem_ff, rad_ff[SQ_RW-1:SQ_RW-2]};
      trial = {2'b0, root_ff, 2'b01};
      diff = rem2 - trial;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rad_in = req.rad;
         rem_in = '0;
         root_in = '0;
         cnt_in = 6'(SQ_QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[SQ_RW-3:0], 2'b00};
         if (rem2 >= trial) begin
            rem_in = diff[SQ_QW+1:0];
            root_in = {root_ff[SQ_QW-2:0], 1'b1};
         end else begin
            rem_in = rem2[SQ_QW+1:0];
            root_in = {root_ff[SQ_QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire
